[rtl/core/iae_pkg.sv]
// ----------------------------------------------------------------------------
// iae_pkg
// Shared types and codes for the indexed array with insert and erase.
// ----------------------------------------------------------------------------
package iae_pkg;

   typedef enum logic [2:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_INSERT = 3'd2,
      KIND_ERASE  = 3'd3,
      KIND_READ   = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SHIFT = 2'b10
   } state_type;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned FIELD_W = 7;

   typedef struct packed {
      logic push;
      logic insert;
      logic erase;
      logic rd_load;
      logic rd_shift;
   } cell_ctl_type;

endpackage

[rtl/core/indexed_array_insert_erase.sv]
// ----------------------------------------------------------------------------
// indexed_array_insert_erase
// Fixed-capacity ordered array with push, pop, insert, erase, read and clear.
//
// The array is a row of CAPACITY cells; insert and erase move every later
// entry one place at once, so push, pop, insert, erase, clear and any
// rejected request give their word in the cycle after acceptance. A good
// read snapshots the row into a read-out chain and shifts it down by the
// position before its word is loaded; that chain sets the read time.
// One request is in flight at a time. Count and free slots are reported in
// their low 7 bits. Entries are not cleared by reset.
// ----------------------------------------------------------------------------
module indexed_array_insert_erase #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_kind,
   input  logic [iae_pkg::FIELD_W-1:0]       req_position,
   input  logic signed [iae_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [iae_pkg::DATA_W-1:0] rsp_read_value,
   output logic [iae_pkg::FIELD_W-1:0]       rsp_element_count,
   output logic [iae_pkg::FIELD_W-1:0]       rsp_free_slots
);
   import iae_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned EW = (CW > FIELD_W) ? CW : FIELD_W;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_rd_ff, rsp_rd_in;

   cell_ctl_type      ctl;
   logic [EW-1:0]     pos_ext, cnt_ext, cap_ext, free_ext;
   logic              req_fire, rsp_fire, rd_start, rsp_load, is_full, is_empty;
   status_type        status_new;
   logic [DATA_W-1:0] rd_new;

   logic [DATA_W-1:0] cell_val [CAPACITY];
   logic [DATA_W-1:0] rd_val   [CAPACITY];

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign pos_ext   = EW'(req_position);
   assign cnt_ext   = EW'(count_ff);
   assign cap_ext   = EW'(CAPACITY);
   assign is_full   = (cnt_ext == cap_ext);
   assign is_empty  = (count_ff == '0);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_cnt_in  = rd_cnt_ff;
      ctl        = '0;
      rd_start   = 1'b0;
      rsp_load   = 1'b0;
      status_new = STATUS_OK;
      rd_new     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               unique case (kind_type'(req_kind))
                  KIND_PUSH: begin
                     if (is_full) begin
                        status_new = STATUS_FULL;
                     end else begin
                        ctl.push = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_POP: begin
                     if (is_empty) begin
                        status_new = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  KIND_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        status_new = STATUS_BAD_INDEX;
                     end else if (is_full) begin
                        status_new = STATUS_FULL;
                     end else begin
                        ctl.insert = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  KIND_ERASE: begin
                     if (pos_ext >= cnt_ext) begin
                        status_new = STATUS_BAD_INDEX;
                     end else begin
                        ctl.erase = 1'b1;
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  KIND_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        status_new = STATUS_BAD_INDEX;
                     end else begin
                        rsp_load    = 1'b0;
                        rd_start    = 1'b1;
                        ctl.rd_load = 1'b1;
                        rd_cnt_in   = pos_ext[IW-1:0];
                        state_in    = ST_SHIFT;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (rd_cnt_ff == '0) begin
               rsp_load = 1'b1;
               rd_new   = rd_val[0];
               state_in = ST_IDLE;
            end else begin
               ctl.rd_shift = 1'b1;
               rd_cnt_in    = rd_cnt_ff - IW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rd_in     = rsp_rd_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_new;
         rsp_rd_in     = rd_new;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_cnt_ff     <= rd_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rd_ff     <= rsp_rd_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_v, right_v, rd_r;
      if (i == 0) begin : g_first
         assign left_v = cell_val[i];
      end else begin : g_mid
         assign left_v = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_val[i];
         assign rd_r    = rd_val[i];
      end else begin : g_inner
         assign right_v = cell_val[i+1];
         assign rd_r    = rd_val[i+1];
      end
      iae_cell #(
         .INDEX (i),
         .EW    (EW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (pos_ext),
         .cnt         (cnt_ext),
         .wr_value    (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .rd_right    (rd_r),
         .value       (cell_val[i]),
         .rd_value    (rd_val[i])
      );
   end

   assign free_ext          = cap_ext - cnt_ext;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_rd_ff;
   assign rsp_element_count = cnt_ext[FIELD_W-1:0];
   assign rsp_free_slots    = free_ext[FIELD_W-1:0];

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      EW'(count_ff) <= cap_ext)
      else $error("element count above capacity");

   a_shift_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> !rsp_valid_ff)
      else $error("result pending during read shift");

   a_prompt_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !rd_start) |=> rsp_valid_ff)
      else $error("single-cycle request gave no word");

   a_shift_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rd_cnt_ff == '0) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("read shift did not finish");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(count_ff))
      else $error("count moved while word pending");

endmodule

[rtl/core/iae_cell.sv]
// ----------------------------------------------------------------------------
// iae_cell
// One array slot: holds one element and one stage of the read-out chain.
// ----------------------------------------------------------------------------
module iae_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned EW    = 7
) (
   input  logic                            clock,
   input  iae_pkg::cell_ctl_type           ctl,
   input  logic [EW-1:0]                   pos,
   input  logic [EW-1:0]                   cnt,
   input  logic [iae_pkg::DATA_W-1:0]      wr_value,
   input  logic [iae_pkg::DATA_W-1:0]      left_value,
   input  logic [iae_pkg::DATA_W-1:0]      right_value,
   input  logic [iae_pkg::DATA_W-1:0]      rd_right,
   output logic [iae_pkg::DATA_W-1:0]      value,
   output logic [iae_pkg::DATA_W-1:0]      rd_value
);
   import iae_pkg::*;

   localparam logic [EW-1:0] IDX = EW'(INDEX);

   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] rd_ff, rd_in;

   always_comb begin
      val_in = val_ff;
      if (ctl.push && (cnt == IDX)) begin
         val_in = wr_value;
      end else if (ctl.insert) begin
         if (pos == IDX) begin
            val_in = wr_value;
         end else if (IDX > pos) begin
            val_in = left_value;
         end
      end else if (ctl.erase && (IDX >= pos)) begin
         val_in = right_value;
      end

      rd_in = rd_ff;
      if (ctl.rd_load) begin
         rd_in = val_ff;
      end else if (ctl.rd_shift) begin
         rd_in = rd_right;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rd_ff  <= rd_in;
   end

   assign value    = val_ff;
   assign rd_value = rd_ff;

endmodule

[test/indexed_array_insert_erase_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_insert_erase_tb
// Self-checking bench for the indexed array. Request words are driven over a
// valid/ready channel. A scoreboard class predicts every result word from its
// own copy of the array and compares each field in order. A directed opener
// hits the boundaries, bad-index and empty codes. Random traffic then
// alternates growing and shrinking the array under four sender/receiver
// idle mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------

typedef struct {
   logic [1:0]  status;
   logic [31:0] read_value;
   logic [6:0]  count;
   logic [6:0]  free;
} array_word_type;

class array_scoreboard_type #(int CAP = 64);
   logic [31:0]    slots [CAP];
   int             fill;
   int             errors;
   int             accepted;
   int             peak;
   int             seen_status [4];
   array_word_type pending [$];

   function void note_request(input logic [2:0] kind, input logic [6:0] position,
                              input logic [31:0] value);
      array_word_type w;
      int             pos;
      pos = position;
      w.status = iae_pkg::STATUS_OK;
      w.read_value = '0;
      case (kind)
         iae_pkg::KIND_PUSH: begin
            if (fill >= CAP) begin
               w.status = iae_pkg::STATUS_FULL;
            end else begin
               slots[fill] = value;
               fill++;
            end
         end
         iae_pkg::KIND_POP: begin
            if (fill == 0) w.status = iae_pkg::STATUS_EMPTY;
            else fill--;
         end
         iae_pkg::KIND_INSERT: begin
            if (pos > fill) begin
               w.status = iae_pkg::STATUS_BAD_INDEX;
            end else if (fill >= CAP) begin
               w.status = iae_pkg::STATUS_FULL;
            end else begin
               for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
               slots[pos] = value;
               fill++;
            end
         end
         iae_pkg::KIND_ERASE: begin
            if (pos >= fill) begin
               w.status = iae_pkg::STATUS_BAD_INDEX;
            end else begin
               for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
               fill--;
            end
         end
         iae_pkg::KIND_READ: begin
            if (pos >= fill) w.status = iae_pkg::STATUS_BAD_INDEX;
            else w.read_value = slots[pos];
         end
         iae_pkg::KIND_CLEAR: fill = 0;
         default: ;
      endcase
      w.count = 7'(fill);
      w.free = 7'(CAP - fill);
      if (fill > peak) peak = fill;
      seen_status[w.status]++;
      accepted++;
      pending = {pending, w};
   endfunction

   function void compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_response(input logic [1:0] status, input logic [31:0] read_value,
                                input logic [6:0] count, input logic [6:0] free);
      array_word_type w;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result word, expected none actual %h/%h/%h/%h",
                  $time, status, read_value, count, free);
         errors++;
         return;
      end
      w = pending.pop_front();
      compare_field("status", 32'(w.status), 32'(status));
      compare_field("read_value", w.read_value, read_value);
      compare_field("element_count", 32'(w.count), 32'(count));
      compare_field("free_slots", 32'(w.free), 32'(free));
   endfunction

   function int outstanding();
      return pending.size();
   endfunction
endclass

module indexed_array_insert_erase_tb;
   import iae_pkg::*;

   localparam int CAPACITY       = 64;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_kind;
   logic [6:0]        req_position;
   logic signed [31:0] req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic signed [31:0] rsp_read_value;
   logic [6:0]        rsp_element_count;
   logic [6:0]        rsp_free_slots;

   array_scoreboard_type #(CAPACITY) sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_ask = 1'b0;
   int hold_left = 0;
   bit grow = 1'b1;
   int quiet;
   int idle_table [4] = '{0, 48, 0, 14};
   int stall_table [4] = '{0, 0, 48, 14};

   indexed_array_insert_erase #(.CAPACITY(CAPACITY)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_free_slots    (rsp_free_slots)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_kind, req_position, req_value);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_read_value, rsp_element_count, rsp_free_slots);
   end

   initial begin
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("indexed_array_insert_erase_tb: FAIL");
      $finish;
   end

   // receiver: random stalls, plus a long hold when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [2:0] kind, input logic [6:0] position,
                            input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_position <= position;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [2:0]  kind;
      logic [6:0]  position;
      logic [31:0] value;
      int          r;
      int          n;
      if ($urandom_range(79) == 0) grow = !grow;
      n = sb.fill;
      r = $urandom_range(99);
      if (grow) begin
         if (r < 40)      kind = KIND_PUSH;
         else if (r < 48) kind = KIND_POP;
         else if (r < 70) kind = KIND_INSERT;
         else if (r < 78) kind = KIND_ERASE;
         else if (r < 96) kind = KIND_READ;
         else if (r < 98) kind = KIND_SPARE_LO;
         else             kind = KIND_SPARE_HI;
      end else begin
         if (r < 12)      kind = KIND_PUSH;
         else if (r < 42) kind = KIND_POP;
         else if (r < 52) kind = KIND_INSERT;
         else if (r < 77) kind = KIND_ERASE;
         else if (r < 94) kind = KIND_READ;
         else if (r < 97) kind = KIND_CLEAR;
         else if (r < 99) kind = KIND_SPARE_LO;
         else             kind = KIND_SPARE_HI;
      end
      r = $urandom_range(99);
      if (r < 8)                position = 7'($urandom_range(127));
      else if (r < 16)          position = 7'(n);
      else if (r < 22 && n > 0) position = 7'(n - 1);
      else if (n > 0)           position = 7'($urandom_range(n - 1));
      else                      position = '0;
      r = $urandom_range(99);
      if (r < 5)       value = 32'h8000_0000;
      else if (r < 10) value = 32'h7fff_ffff;
      else if (r < 13) value = 32'h0000_0000;
      else if (r < 15) value = 32'hffff_ffff;
      else             value = $urandom;
      send_word(kind, position, value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   initial begin
      sb = new();
      req_valid = 1'b0;
      req_kind = KIND_PUSH;
      req_position = '0;
      req_value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(KIND_READ,   7'd0,   32'h0);
      send_word(KIND_POP,    7'd0,   32'h0);
      send_word(KIND_ERASE,  7'd0,   32'h0);
      send_word(KIND_INSERT, 7'd1,   32'h1111_1111);
      send_word(KIND_INSERT, 7'd127, 32'h2222_2222);
      send_word(KIND_INSERT, 7'd0,   32'h8000_0000);
      send_word(KIND_PUSH,   7'd0,   32'h7fff_ffff);
      send_word(KIND_PUSH,   7'd0,   32'h0000_0000);
      send_word(KIND_INSERT, 7'd1,   32'hffff_ffff);
      send_word(KIND_INSERT, 7'd4,   32'h1234_5678);
      send_word(KIND_READ,   7'd0,   32'h0);
      send_word(KIND_READ,   7'd4,   32'h0);
      send_word(KIND_READ,   7'd5,   32'h0);
      send_word(KIND_READ,   7'd64,  32'h0);
      send_word(KIND_ERASE,  7'd1,   32'h0);
      send_word(KIND_ERASE,  7'd3,   32'h0);
      send_word(KIND_ERASE,  7'd3,   32'h0);
      send_word(KIND_SPARE_LO, 7'd127, 32'hffff_ffff);
      send_word(KIND_SPARE_HI, 7'd0,   32'h0);
      send_word(KIND_POP,    7'd0,   32'h0);
      send_word(KIND_READ,   7'd1,   32'h0);
      send_word(KIND_CLEAR,  7'd0,   32'h0);
      send_word(KIND_READ,   7'd0,   32'h0);
      send_word(KIND_PUSH,   7'd0,   32'h5a5a_5a5a);
      send_word(KIND_READ,   7'd0,   32'h0);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_table[ph];
         stall_pct = stall_table[ph];
         grow = 1'b1;
         if (ph == 2) hold_ask = 1'b1;
         repeat (ITEMS_PER_PHASE) send_random();
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d request words over four idle mixes and a %0d-cycle receiver hold",
               sb.accepted, HOLD_CYCLES);
      $display("statuses ok %0d, bad index %0d, full %0d, empty %0d; deepest fill %0d of %0d",
               sb.seen_status[STATUS_OK], sb.seen_status[STATUS_BAD_INDEX],
               sb.seen_status[STATUS_FULL], sb.seen_status[STATUS_EMPTY],
               sb.peak, CAPACITY);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("indexed_array_insert_erase_tb: PASS");
      end else begin
         if (sb.outstanding() != 0)
            $display("%0t: %0d result words never arrived, expected 0 actual %0d",
                     $time, sb.outstanding(), sb.outstanding());
         $display("indexed_array_insert_erase_tb: FAIL");
      end
      $finish;
   end
endmodule
